>>> rtl/u8u2_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
package u8u2_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned RemW  = 2;

  localparam logic [ByteW-1:0] Lead3Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Bits = 8'h0F;
  localparam logic [ByteW-1:0] Lead2Bits = 8'h1F;
  localparam logic [ByteW-1:0] ContBits  = 8'h3F;

  // Continuation bytes still expected in the current sequence.
  localparam logic [RemW-1:0] RemNone = 2'd0;
  localparam logic [RemW-1:0] RemOne  = 2'd1;
  localparam logic [RemW-1:0] RemTwo  = 2'd2;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             is_terminator;
  } res_t;

endpackage

>>> rtl/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder.
// Takes one UTF-8 byte per item and gives one 16-bit UCS-2 code unit for each
// single-byte character, each completed two- or three-byte sequence (four-byte
// leads decode as three-byte ones), and a unit of zero flagged as terminator
// for a zero lead byte; continuation bytes are not checked. A byte passes an
// input register, combinational decode logic and a result register, where its
// unit waits until the consumer takes it; one byte can be accepted every cycle
// while the input does not stall.
// The input stalls only while the result register holds a unit that the
// consumer has not taken and the waiting byte would produce another one.
module utf8_to_ucs2_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [u8u2_pkg::ByteW-1:0] in_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [u8u2_pkg::UnitW-1:0] code_unit_o,
  output logic                       is_terminator_o
);
  import u8u2_pkg::*;

  logic             byte_vld;
  logic [ByteW-1:0] byte_q;
  logic             produce;
  logic             out_free;
  logic             go;
  res_t             res;

  // Bytes that give no unit move on even while the result register is full.
  assign go = byte_vld && (out_free || !produce);

  u8u2_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .take_i     (go),
    .vld_o      (byte_vld),
    .byte_o     (byte_q),
    .in_stall_o (in_stall_o)
  );

  u8u2_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_q),
    .go_i      (go),
    .produce_o (produce),
    .res_o     (res)
  );

  u8u2_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (go && produce),
    .res_i           (res),
    .out_stall_i     (out_stall_i),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .code_unit_o     (code_unit_o),
    .is_terminator_o (is_terminator_o)
  );

endmodule

>>> rtl/u8u2_in_reg.sv
// Input register stage that holds one byte until the decoder takes it.
module u8u2_in_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [u8u2_pkg::ByteW-1:0] in_byte_i,
  input  logic                     take_i,
  output logic                     vld_o,
  output logic [u8u2_pkg::ByteW-1:0] byte_o,
  output logic                     in_stall_o
);
  import u8u2_pkg::*;

  logic             vld_q, vld_d;
  logic [ByteW-1:0] byte_q;
  logic             accept;

  // The stage is free when it is empty or its item leaves this cycle.
  assign in_stall_o = vld_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

>>> rtl/u8u2_decode.sv
// Sequence state and the per-byte decode logic.
module u8u2_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [u8u2_pkg::ByteW-1:0] byte_i,
  input  logic                       go_i,
  output logic                       produce_o,
  output u8u2_pkg::res_t             res_o
);
  import u8u2_pkg::*;

  logic [RemW-1:0]  rem_q, rem_d;
  logic [UnitW-1:0] partial_q, partial_d;
  logic [UnitW-1:0] cont6;

  assign cont6 = {{(UnitW-ByteW){1'b0}}, byte_i & ContBits};

  always_comb begin
    rem_d                 = rem_q;
    partial_d             = partial_q;
    produce_o             = 1'b0;
    res_o.code_unit       = '0;
    res_o.is_terminator   = 1'b0;
    priority if (rem_q[1]) begin
      partial_d = partial_q | (cont6 << 6);
      rem_d     = RemOne;
    end else if (rem_q == RemOne) begin
      produce_o       = 1'b1;
      res_o.code_unit = partial_q | cont6;
      rem_d           = RemNone;
      partial_d       = '0;
    end else if (byte_i == '0) begin
      produce_o           = 1'b1;
      res_o.is_terminator = 1'b1;
    end else if ((byte_i & Lead3Mask) == Lead3Mask) begin
      partial_d = {{(UnitW-ByteW){1'b0}}, byte_i & Lead3Bits} << 12;
      rem_d     = RemTwo;
    end else if ((byte_i & Lead2Mask) == Lead2Mask) begin
      partial_d = {{(UnitW-ByteW){1'b0}}, byte_i & Lead2Bits} << 6;
      rem_d     = RemOne;
    end else begin
      produce_o       = 1'b1;
      res_o.code_unit = {{(UnitW-ByteW){1'b0}}, byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= RemNone;
      partial_q <= '0;
    end else if (go_i) begin
      rem_q     <= rem_d;
      partial_q <= partial_d;
    end
  end

endmodule

>>> rtl/u8u2_out_reg.sv
// Result register that holds a code unit until the consumer takes it.
module u8u2_out_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  u8u2_pkg::res_t             res_i,
  input  logic                       out_stall_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  output logic [u8u2_pkg::UnitW-1:0] code_unit_o,
  output logic                       is_terminator_o
);
  import u8u2_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o     = vld_q;
  assign code_unit_o     = res_q.code_unit;
  assign is_terminator_o = res_q.is_terminator;

endmodule

>>> rtl/u8u2_checker.sv
// Port-level checks for the UTF-8 to UCS-2 decoder and their binding.
module u8u2_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [u8u2_pkg::ByteW-1:0] in_byte_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [u8u2_pkg::UnitW-1:0] code_unit_o,
  input logic                       is_terminator_o
);

  // A stalled item keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_unit_o)
      && $stable(is_terminator_o))
    else $error("stalled result item changed");

  // The input is held back only by a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // The terminator always carries a zero code unit.
  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_terminator_o |-> code_unit_o == '0)
    else $error("terminator with nonzero code unit");

  // A result appears on an empty output only after a byte was taken and has
  // passed the input register and the result register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result item without an accepted byte");

endmodule

bind utf8_to_ucs2_decoder u8u2_checker u_u8u2_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the UTF-8 to UCS-2 decoder.
module tb_top;
  import u8u2_pkg::*;

  localparam int unsigned RandomBytes = 1950;
  localparam int unsigned QuietFrom   = 1700;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DirRows     = 23;

  typedef struct {
    logic [ByteW-1:0] in_byte;
    bit               typed;
    logic [UnitW-1:0] code_unit;
    logic             is_terminator;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [ByteW-1:0] in_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [UnitW-1:0] code_unit_o;
  logic             is_terminator_o;

  // Decoder state as seen by the predictor.
  logic [RemW-1:0]  pend_cnt  = RemNone;
  logic [UnitW-1:0] pend_unit = '0;

  res_t unit_q[$];
  int   mismatch_cnt = 0;
  int   cycle_cnt    = 0;
  int   bytes_fed    = 0;
  int   units_seen   = 0;
  int   terms_seen   = 0;
  bit   quiet        = 1'b0;

  // Rows typed in by hand carry their unit; the others are left to the predictor.
  stim_row_t dir_rows [DirRows] = '{
    '{8'h00, 1'b1, 16'h0000, 1'b1},
    '{8'h41, 1'b1, 16'h0041, 1'b0},
    '{8'h7F, 1'b1, 16'h007F, 1'b0},
    '{8'h80, 1'b1, 16'h0080, 1'b0},
    '{8'hBF, 1'b1, 16'h00BF, 1'b0},
    '{8'hC0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b1, 16'h0000, 1'b0},
    '{8'hDF, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b1, 16'h07FF, 1'b0},
    '{8'hE0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b1, 16'h0000, 1'b0},
    '{8'hEF, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b1, 16'hFFFF, 1'b0},
    '{8'hF0, 1'b0, 16'h0000, 1'b0},
    '{8'h9F, 1'b0, 16'h0000, 1'b0},
    '{8'h98, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 16'h0000, 1'b0},
    '{8'h40, 1'b0, 16'h0000, 1'b0},
    '{8'h41, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b1, 16'h0000, 1'b1}
  };

  utf8_to_ucs2_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_unit_o    (code_unit_o),
    .is_terminator_o(is_terminator_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  // Advances the predicted decoder by one byte; returns 1 when a unit comes out.
  function automatic bit decode_step(input logic [ByteW-1:0] b, output res_t unit);
    unit = '0;
    if (pend_cnt >= RemTwo) begin
      pend_unit = pend_unit | (UnitW'(b & ContBits) << 6);
      pend_cnt  = RemOne;
      return 1'b0;
    end
    if (pend_cnt == RemOne) begin
      unit.code_unit = pend_unit | UnitW'(b & ContBits);
      pend_cnt  = RemNone;
      pend_unit = '0;
      return 1'b1;
    end
    if (b == '0) begin
      unit.is_terminator = 1'b1;
      return 1'b1;
    end
    if ((b & Lead3Mask) == Lead3Mask) begin
      pend_unit = UnitW'(b & Lead3Bits) << 12;
      pend_cnt  = RemTwo;
      return 1'b0;
    end
    if ((b & Lead2Mask) == Lead2Mask) begin
      pend_unit = UnitW'(b & Lead2Bits) << 6;
      pend_cnt  = RemOne;
      return 1'b0;
    end
    unit.code_unit = UnitW'(b);
    return 1'b1;
  endfunction

  function automatic logic [ByteW-1:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // Called at a falling edge; returns at the falling edge after the byte is taken.
  task automatic feed_byte(input logic [ByteW-1:0] b, input bit typed, input res_t want);
    int   gap;
    res_t unit;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_fed++;
    if (decode_step(b, unit)) unit_q.push_back(typed ? want : unit);
    @(negedge clk_i);
  endtask

  initial begin : stall_gen
    int n;
    bit hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(0, 2) == 0);
      n = hold ? $urandom_range(1, 16) : $urandom_range(1, 40);
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= hold && !quiet;
      end
    end
  end

  always @(posedge clk_i) begin : check_units
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      units_seen++;
      if (is_terminator_o) terms_seen++;
      if (unit_q.size() == 0) begin
        report_mismatch($sformatf("unit %h arrived with none pending", code_unit_o));
      end else begin
        want = unit_q.pop_front();
        if (code_unit_o !== want.code_unit)
          report_mismatch($sformatf("code_unit %h, want %h", code_unit_o, want.code_unit));
        if (is_terminator_o !== want.is_terminator)
          report_mismatch($sformatf("is_terminator %b, want %b", is_terminator_o,
                                    want.is_terminator));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d units still pending", cycle_cnt, unit_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int   roll;
    int   dir_fed;
    res_t none;
    none       = '0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      feed_byte(dir_rows[i].in_byte, dir_rows[i].typed,
                '{code_unit: dir_rows[i].code_unit, is_terminator: dir_rows[i].is_terminator});
    dir_fed = bytes_fed;

    // Mostly well-formed characters, with strays, broken sequences and raw noise mixed in.
    while (bytes_fed < dir_fed + RandomBytes) begin
      if (bytes_fed >= dir_fed + QuietFrom) quiet = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        feed_byte(8'($urandom_range(1, 127)), 1'b0, none);
      end else if (roll < 50) begin
        feed_byte({3'b110, 5'($urandom_range(0, 31))}, 1'b0, none);
        feed_byte(cont_byte(), 1'b0, none);
      end else if (roll < 70) begin
        feed_byte({4'b1110, 4'($urandom_range(0, 15))}, 1'b0, none);
        feed_byte(cont_byte(), 1'b0, none);
        feed_byte(cont_byte(), 1'b0, none);
      end else if (roll < 75) begin
        // Four-byte and longer leads decode as three bytes; the fourth is a new lead.
        feed_byte(8'($urandom_range(8'hF0, 8'hFF)), 1'b0, none);
        repeat (3) feed_byte(cont_byte(), 1'b0, none);
      end else if (roll < 82) begin
        feed_byte(8'h00, 1'b0, none);
      end else if (roll < 88) begin
        feed_byte(cont_byte(), 1'b0, none);
      end else if (roll < 94) begin
        // A lead followed by arbitrary bytes in continuation position, zero included.
        feed_byte(8'($urandom_range(8'hC0, 8'hFF)), 1'b0, none);
        repeat ($urandom_range(1, 2))
          feed_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                    1'b0, none);
      end else begin
        feed_byte(8'($urandom_range(0, 255)), 1'b0, none);
      end
    end
    in_valid_i <= 1'b0;

    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Fed %0d bytes, %0d of them from the directed table, in %0d cycles.",
             bytes_fed, dir_fed, cycle_cnt);
    $display("Checked %0d code units, %0d of them string terminators.", units_seen, terms_seen);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
